>>> hw/rtl/assert_macros.svh
// Assertion helpers for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error("assertion failed");

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> hw/rtl/oae_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package oae_pkg;

    localparam int MUL_W  = 34;
    localparam int MUL_PW = 2 * MUL_W;
    localparam int CW     = 36;

    localparam logic [1:0] ACT_X    = 2'd0;
    localparam logic [1:0] ACT_Y    = 2'd1;
    localparam logic [1:0] ACT_Z    = 2'd2;
    localparam logic [1:0] ACT_AXIS = 2'd3;

    localparam logic signed [CW-1:0] GAIN_Q30 = 36'sd652032874;
    localparam logic signed [CW-1:0] PI_Q30   = 36'sd3373259426;
    localparam logic signed [31:0]   ONE_Q30  = 32'sd1073741824;
    localparam logic signed [MUL_W-1:0] DEG64_TO_RAD = 34'sd292818;
    localparam logic signed [16:0] FULL_TURN    = 17'sd23040;
    localparam logic signed [16:0] HALF_TURN    = 17'sd11520;
    localparam logic signed [16:0] QUARTER_TURN = 17'sd5760;
    localparam logic signed [18:0] EULER_LIMIT  = 19'sd25736;

    localparam logic [29:0] ATAN_TAB [24] = '{
        30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158,
        30'd67021686,  30'd33543515,  30'd16775850,  30'd8388437,
        30'd4194282,   30'd2097149,   30'd1048575,   30'd524287,
        30'd262143,    30'd131071,    30'd65535,     30'd32767,
        30'd16383,     30'd8191,      30'd4095,      30'd2047,
        30'd1023,      30'd511,       30'd255,       30'd127
    };

    typedef struct packed {
        logic start;
        logic vec;
    } cordic_req_t;

endpackage
`default_nettype wire

>>> hw/rtl/orientation_accumulator_euler.sv
`timescale 1ns / 1ps
`default_nettype none
// Orientation accumulator: holds a 3x3 rotation matrix (identity after reset),
// post-multiplies it by the axis-angle rotation of each input transaction and
// returns one result transaction with the Euler angles of the updated matrix.
// All work runs one item at a time through a single 34x34 multiplier, one
// CORDIC unit shared by sine/cosine and the three arctangents, one square root
// unit and one divider, stepped by a sequencer. A singular matrix skips one
// arctangent. An arbitrary axis adds the axis length, a square root and three
// 32-step divisions; a zero axis skips the rotation and the matrix update. The
// block accepts a new transaction as soon as the previous result sits in the
// output register; a result that is still waiting there holds the next one
// back.
module orientation_accumulator_euler import oae_pkg::*; #(
    parameter int MATRIX_WIDTH = 24,
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,  // angle_deg, axis_x, axis_y, axis_z
    input  wire logic [1:0]  s_tuser,  // action
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,  // euler_x, euler_y, euler_z
    output logic [1:0]       m_tuser   // singular, bad_axis
);

`include "assert_macros.svh"

    localparam int MFRAC = MATRIX_WIDTH - 2;
    localparam int SHIFT = 32 - MATRIX_WIDTH;
    localparam int NSTEPS = (CORDIC_STEPS > 24) ? 24 : ((CORDIC_STEPS < 1) ? 1 : CORDIC_STEPS);
    localparam logic [63:0] SING_LIMIT = ((64'd1 << MFRAC) + 64'd999999) / 64'd1000000;
    localparam logic signed [MATRIX_WIDTH-1:0] MAT_ONE = MATRIX_WIDTH'(64'd1 << MFRAC);
    localparam logic signed [35:0] MAT_MAX = (36'sd1 <<< (MATRIX_WIDTH - 1)) - 36'sd1;
    localparam logic signed [35:0] MAT_MIN = -MAT_MAX - 36'sd1;
    localparam logic signed [35:0] R_MAX = 36'sd1073741824;

    typedef enum logic [14:0] {
        S_IDLE   = 15'b000000000000001,
        S_LEN    = 15'b000000000000010,
        S_NSQRT  = 15'b000000000000100,
        S_DIV    = 15'b000000000001000,
        S_ZMUL   = 15'b000000000010000,
        S_ROT    = 15'b000000000100000,
        S_TMUL   = 15'b000000001000000,
        S_SUMUL  = 15'b000000010000000,
        S_RMUL   = 15'b000000100000000,
        S_MMUL   = 15'b000001000000000,
        S_COMMIT = 15'b000010000000000,
        S_SYMUL  = 15'b000100000000000,
        S_SYSQRT = 15'b001000000000000,
        S_ATAN   = 15'b010000000000000,
        S_DONE   = 15'b100000000000000
    } state_t;

    state_t state_reg, state_next;
    logic ph_reg, ph_next;
    logic [1:0] cnt_reg, cnt_next;
    logic [1:0] col_reg, col_next;
    logic [1:0] row_reg, row_next;
    logic [1:0] kk_reg, kk_next;
    logic signed [15:0] angle_reg, angle_next;
    logic signed [15:0] axis_reg [3];
    logic signed [15:0] axis_next [3];
    logic bad_reg, bad_next;
    logic [31:0] len2_reg, len2_next;
    logic [31:0] len_reg, len_next;
    logic signed [31:0] u_reg [3];
    logic signed [31:0] u_next [3];
    logic neg_reg, neg_next;
    logic signed [CW-1:0] zang_reg, zang_next;
    logic signed [MUL_W-1:0] c_reg, c_next;
    logic signed [MUL_W-1:0] s_reg, s_next;
    logic signed [MUL_W-1:0] omc_reg, omc_next;
    logic signed [MUL_W-1:0] t_reg [3];
    logic signed [MUL_W-1:0] t_next [3];
    logic signed [MUL_W-1:0] su_reg [3];
    logic signed [MUL_W-1:0] su_next [3];
    logic signed [31:0] r_reg [9];
    logic signed [31:0] r_next [9];
    logic signed [65:0] acc_reg, acc_next;
    logic signed [MATRIX_WIDTH-1:0] mnew_reg [9];
    logic signed [MATRIX_WIDTH-1:0] mnew_next [9];
    logic signed [MATRIX_WIDTH-1:0] mat_reg [9];
    logic signed [MATRIX_WIDTH-1:0] mat_next [9];
    logic [63:0] sum_reg, sum_next;
    logic [31:0] sy_reg, sy_next;
    logic sing_reg, sing_next;
    logic signed [15:0] ex_reg, ex_next;
    logic signed [15:0] ey_reg, ey_next;
    logic signed [15:0] ez_reg, ez_next;
    logic [47:0] m_tdata_reg, m_tdata_next;
    logic [1:0] m_tuser_reg, m_tuser_next;
    logic m_tvalid_reg, m_tvalid_next;

    logic signed [MUL_W-1:0] mul_a, mul_b;
    logic signed [MUL_PW-1:0] mul_p;
    logic sqrt_start, sqrt_done;
    logic [63:0] sqrt_rad;
    logic [31:0] sqrt_root;
    logic div_start, div_done;
    logic [31:0] div_hi, div_q;
    cordic_req_t cd_req;
    logic signed [CW-1:0] cd_xi, cd_yi, cd_zi, cd_x, cd_y, cd_z;
    logic cd_done_w;

    logic signed [16:0] d0, d1, d2;
    logic d_neg;
    logic [3:0] ridx, midx, widx;
    logic signed [16:0] asx;
    logic [16:0] amag;
    logic signed [CW-1:0] at_y, at_x;
    logic at_zero;
    logic signed [MUL_W-1:0] cn, sn;
    logic signed [35:0] extra, rsum;
    logic signed [65:0] acc_new, acc_rnd;
    logic signed [35:0] mval;
    logic signed [CW-1:0] zrnd;
    logic signed [18:0] zq;
    logic signed [15:0] eres;

    oae_mul u_mul (.aclk(aclk), .a(mul_a), .b(mul_b), .p(mul_p));

    oae_sqrt u_sqrt (
        .aclk(aclk), .aresetn(aresetn), .start(sqrt_start), .radicand(sqrt_rad),
        .done(sqrt_done), .root(sqrt_root)
    );

    oae_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .dividend_hi(div_hi),
        .divisor(len_reg), .done(div_done), .quotient(div_q)
    );

    oae_cordic #(.STEPS(NSTEPS)) u_cordic (
        .aclk(aclk), .aresetn(aresetn), .req(cd_req), .x_in(cd_xi), .y_in(cd_yi),
        .z_in(cd_zi), .done(cd_done_w), .x_out(cd_x), .y_out(cd_y), .z_out(cd_z)
    );

    // Datapath selection shared by all states.
    always_comb begin
        d0 = 17'(angle_reg);
        if (d0 > HALF_TURN) begin
            d1 = d0 - FULL_TURN;
        end else if (d0 < -HALF_TURN) begin
            d1 = d0 + FULL_TURN;
        end else begin
            d1 = d0;
        end
        d_neg = 1'b1;
        if (d1 > QUARTER_TURN) begin
            d2 = d1 - HALF_TURN;
        end else if (d1 < -QUARTER_TURN) begin
            d2 = d1 + HALF_TURN;
        end else begin
            d2 = d1;
            d_neg = 1'b0;
        end

        ridx = {2'b00, col_reg} * 4'd3 + {2'b00, kk_reg};
        midx = {2'b00, kk_reg} * 4'd3 + {2'b00, row_reg};
        widx = {2'b00, col_reg} * 4'd3 + {2'b00, row_reg};

        asx  = 17'(axis_reg[cnt_reg]);
        amag = asx[16] ? 17'(-asx) : 17'(asx);
        div_hi = 32'({amag, 14'b0});

        case (cnt_reg)
            2'd0: begin
                at_y = -CW'(mat_reg[6]);
                at_x = $signed({{(CW-32){1'b0}}, sy_reg});
            end
            2'd1: begin
                if (sing_reg) begin
                    at_y = -CW'(mat_reg[5]);
                    at_x = CW'(mat_reg[4]);
                end else begin
                    at_y = CW'(mat_reg[7]);
                    at_x = CW'(mat_reg[8]);
                end
            end
            default: begin
                at_y = CW'(mat_reg[3]);
                at_x = CW'(mat_reg[0]);
            end
        endcase
        at_zero = (at_y == '0) && (at_x == '0);

        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_LEN: begin
                mul_a = MUL_W'(axis_reg[cnt_reg]);
                mul_b = MUL_W'(axis_reg[cnt_reg]);
            end
            S_ZMUL: begin
                mul_a = MUL_W'(d2);
                mul_b = DEG64_TO_RAD;
            end
            S_TMUL: begin
                mul_a = omc_reg;
                mul_b = MUL_W'(u_reg[cnt_reg]);
            end
            S_SUMUL: begin
                mul_a = s_reg;
                mul_b = MUL_W'(u_reg[cnt_reg]);
            end
            S_RMUL: begin
                mul_a = t_reg[col_reg];
                mul_b = MUL_W'(u_reg[kk_reg]);
            end
            S_MMUL: begin
                mul_a = MUL_W'(mat_reg[midx]);
                mul_b = MUL_W'(r_reg[ridx]);
            end
            S_SYMUL: begin
                mul_a = (cnt_reg == 2'd0) ? MUL_W'(mat_reg[0]) : MUL_W'(mat_reg[3]);
                mul_b = mul_a;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase

        sqrt_start = !ph_reg && (state_reg == S_NSQRT || state_reg == S_SYSQRT);
        sqrt_rad   = (state_reg == S_NSQRT) ? {len2_reg, 32'b0} : sum_reg;
        div_start  = !ph_reg && (state_reg == S_DIV);

        cd_req.start = !ph_reg && (state_reg == S_ROT || state_reg == S_ATAN);
        cd_req.vec   = (state_reg == S_ATAN);
        cd_xi = (state_reg == S_ATAN) ? (at_x <<< SHIFT) : GAIN_Q30;
        cd_yi = (state_reg == S_ATAN) ? (at_y <<< SHIFT) : '0;
        cd_zi = zang_reg;

        cn = neg_reg ? -MUL_W'(cd_x) : MUL_W'(cd_x);
        sn = neg_reg ? -MUL_W'(cd_y) : MUL_W'(cd_y);

        case (ridx)
            4'd1:    extra = 36'(su_reg[2]);
            4'd2:    extra = -36'(su_reg[1]);
            4'd3:    extra = -36'(su_reg[2]);
            4'd5:    extra = 36'(su_reg[0]);
            4'd6:    extra = 36'(su_reg[1]);
            4'd7:    extra = -36'(su_reg[0]);
            default: extra = 36'(c_reg);
        endcase
        rsum = 36'($signed(mul_p[63:30])) + extra;

        acc_new = ((kk_reg == 2'd0) ? 66'sd0 : acc_reg) + mul_p[65:0];
        acc_rnd = acc_new + (66'sd1 <<< 29);
        mval    = acc_rnd[65:30];

        zrnd = cd_z + (36'sd1 <<< 16);
        zq   = zrnd[35:17];
        if (at_zero) begin
            eres = '0;
        end else if (zq > EULER_LIMIT) begin
            eres = 16'(EULER_LIMIT);
        end else if (zq < -EULER_LIMIT) begin
            eres = 16'(-EULER_LIMIT);
        end else begin
            eres = zq[15:0];
        end
    end

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        ph_next = ph_reg;
        cnt_next = cnt_reg;
        col_next = col_reg;
        row_next = row_reg;
        kk_next = kk_reg;
        angle_next = angle_reg;
        axis_next = axis_reg;
        bad_next = bad_reg;
        len2_next = len2_reg;
        len_next = len_reg;
        u_next = u_reg;
        neg_next = neg_reg;
        zang_next = zang_reg;
        c_next = c_reg;
        s_next = s_reg;
        omc_next = omc_reg;
        t_next = t_reg;
        su_next = su_reg;
        r_next = r_reg;
        acc_next = acc_reg;
        mnew_next = mnew_reg;
        mat_next = mat_reg;
        sum_next = sum_reg;
        sy_next = sy_reg;
        sing_next = sing_reg;
        ex_next = ex_reg;
        ey_next = ey_reg;
        ez_next = ez_reg;
        m_tdata_next = m_tdata_reg;
        m_tuser_next = m_tuser_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    angle_next   = s_tdata[15:0];
                    axis_next[0] = s_tdata[31:16];
                    axis_next[1] = s_tdata[47:32];
                    axis_next[2] = s_tdata[63:48];
                    bad_next  = 1'b0;
                    len2_next = '0;
                    cnt_next  = '0;
                    ph_next   = 1'b0;
                    u_next[0] = (s_tuser == ACT_X) ? ONE_Q30 : '0;
                    u_next[1] = (s_tuser == ACT_Y) ? ONE_Q30 : '0;
                    u_next[2] = (s_tuser == ACT_Z) ? ONE_Q30 : '0;
                    state_next = (s_tuser == ACT_AXIS) ? S_LEN : S_ZMUL;
                end
            end
            S_LEN: begin
                ph_next = !ph_reg;
                if (ph_reg) begin
                    len2_next = len2_reg + mul_p[31:0];
                    cnt_next = cnt_reg + 2'd1;
                    if (cnt_reg == 2'd2) begin
                        cnt_next = '0;
                        if (len2_next == '0) begin
                            bad_next = 1'b1;
                            state_next = S_SYMUL;
                        end else begin
                            state_next = S_NSQRT;
                        end
                    end
                end
            end
            S_NSQRT: begin
                if (!ph_reg) begin
                    ph_next = 1'b1;
                end else if (sqrt_done) begin
                    ph_next = 1'b0;
                    len_next = sqrt_root;
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                if (!ph_reg) begin
                    ph_next = 1'b1;
                end else if (div_done) begin
                    ph_next = 1'b0;
                    u_next[cnt_reg] = axis_reg[cnt_reg][15] ? -$signed(div_q) : $signed(div_q);
                    cnt_next = cnt_reg + 2'd1;
                    if (cnt_reg == 2'd2) begin
                        cnt_next = '0;
                        state_next = S_ZMUL;
                    end
                end
            end
            S_ZMUL: begin
                ph_next = !ph_reg;
                if (ph_reg) begin
                    zang_next = mul_p[CW-1:0];
                    neg_next = d_neg;
                    state_next = S_ROT;
                end
            end
            S_ROT: begin
                if (!ph_reg) begin
                    ph_next = 1'b1;
                end else if (cd_done_w) begin
                    ph_next = 1'b0;
                    c_next = cn;
                    s_next = sn;
                    omc_next = MUL_W'(ONE_Q30) - cn;
                    cnt_next = '0;
                    state_next = S_TMUL;
                end
            end
            S_TMUL: begin
                ph_next = !ph_reg;
                if (ph_reg) begin
                    t_next[cnt_reg] = mul_p[63:30];
                    cnt_next = cnt_reg + 2'd1;
                    if (cnt_reg == 2'd2) begin
                        cnt_next = '0;
                        state_next = S_SUMUL;
                    end
                end
            end
            S_SUMUL: begin
                ph_next = !ph_reg;
                if (ph_reg) begin
                    su_next[cnt_reg] = mul_p[63:30];
                    cnt_next = cnt_reg + 2'd1;
                    if (cnt_reg == 2'd2) begin
                        cnt_next = '0;
                        col_next = '0;
                        kk_next = '0;
                        state_next = S_RMUL;
                    end
                end
            end
            S_RMUL: begin
                ph_next = !ph_reg;
                if (ph_reg) begin
                    if (rsum > R_MAX) begin
                        r_next[ridx] = 32'(R_MAX);
                    end else if (rsum < -R_MAX) begin
                        r_next[ridx] = 32'(-R_MAX);
                    end else begin
                        r_next[ridx] = rsum[31:0];
                    end
                    kk_next = kk_reg + 2'd1;
                    if (kk_reg == 2'd2) begin
                        kk_next = '0;
                        col_next = col_reg + 2'd1;
                        if (col_reg == 2'd2) begin
                            col_next = '0;
                            row_next = '0;
                            state_next = S_MMUL;
                        end
                    end
                end
            end
            S_MMUL: begin
                ph_next = !ph_reg;
                if (ph_reg) begin
                    acc_next = acc_new;
                    kk_next = kk_reg + 2'd1;
                    if (kk_reg == 2'd2) begin
                        if (mval > MAT_MAX) begin
                            mnew_next[widx] = MATRIX_WIDTH'(MAT_MAX);
                        end else if (mval < MAT_MIN) begin
                            mnew_next[widx] = MATRIX_WIDTH'(MAT_MIN);
                        end else begin
                            mnew_next[widx] = mval[MATRIX_WIDTH-1:0];
                        end
                        kk_next = '0;
                        row_next = row_reg + 2'd1;
                        if (row_reg == 2'd2) begin
                            row_next = '0;
                            col_next = col_reg + 2'd1;
                            if (col_reg == 2'd2) begin
                                col_next = '0;
                                state_next = S_COMMIT;
                            end
                        end
                    end
                end
            end
            S_COMMIT: begin
                mat_next = mnew_reg;
                cnt_next = '0;
                state_next = S_SYMUL;
            end
            S_SYMUL: begin
                ph_next = !ph_reg;
                if (ph_reg) begin
                    sum_next = ((cnt_reg == 2'd0) ? 64'd0 : sum_reg) + mul_p[63:0];
                    cnt_next = cnt_reg + 2'd1;
                    if (cnt_reg == 2'd1) begin
                        cnt_next = '0;
                        state_next = S_SYSQRT;
                    end
                end
            end
            S_SYSQRT: begin
                if (!ph_reg) begin
                    ph_next = 1'b1;
                end else if (sqrt_done) begin
                    ph_next = 1'b0;
                    sy_next = sqrt_root;
                    sing_next = sqrt_root < SING_LIMIT[31:0];
                    cnt_next = '0;
                    state_next = S_ATAN;
                end
            end
            S_ATAN: begin
                if (!ph_reg) begin
                    ph_next = 1'b1;
                end else if (cd_done_w) begin
                    ph_next = 1'b0;
                    cnt_next = cnt_reg + 2'd1;
                    case (cnt_reg)
                        2'd0: begin
                            ey_next = eres;
                        end
                        2'd1: begin
                            ex_next = eres;
                            if (sing_reg) begin
                                ez_next = '0;
                                state_next = S_DONE;
                            end
                        end
                        default: begin
                            ez_next = eres;
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tdata_next = {ez_reg, ey_reg, ex_reg};
                    m_tuser_next = {bad_reg, sing_reg};
                    m_tvalid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ph_reg <= 1'b0;
            cnt_reg <= '0;
            col_reg <= '0;
            row_reg <= '0;
            kk_reg <= '0;
            m_tvalid_reg <= 1'b0;
            for (int k = 0; k < 9; k++) begin
                mat_reg[k] <= (k % 4 == 0) ? MAT_ONE : '0;
            end
        end else begin
            state_reg <= state_next;
            ph_reg <= ph_next;
            cnt_reg <= cnt_next;
            col_reg <= col_next;
            row_reg <= row_next;
            kk_reg <= kk_next;
            m_tvalid_reg <= m_tvalid_next;
            mat_reg <= mat_next;
        end
    end

    always_ff @(posedge aclk) begin
        angle_reg <= angle_next;
        axis_reg <= axis_next;
        bad_reg <= bad_next;
        len2_reg <= len2_next;
        len_reg <= len_next;
        u_reg <= u_next;
        neg_reg <= neg_next;
        zang_reg <= zang_next;
        c_reg <= c_next;
        s_reg <= s_next;
        omc_reg <= omc_next;
        t_reg <= t_next;
        su_reg <= su_next;
        r_reg <= r_next;
        acc_reg <= acc_next;
        mnew_reg <= mnew_next;
        sum_reg <= sum_next;
        sy_reg <= sy_next;
        sing_reg <= sing_next;
        ex_reg <= ex_next;
        ey_reg <= ey_next;
        ez_reg <= ez_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // An accepted transaction keeps the input closed while it is worked on.
    `ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    // A finished result waits while the output register still holds an untaken one.
    `ASSERT_NEXT(a_done_waits, aclk, aresetn, (state_reg == S_DONE) && m_tvalid_reg && !m_tready, state_reg == S_DONE)
    // A zero-length axis never reaches the matrix update.
    `ASSERT_ALWAYS(a_bad_no_update, aclk, aresetn, !(bad_reg && ((state_reg == S_MMUL) || (state_reg == S_COMMIT))))

endmodule
`default_nettype wire

>>> hw/rtl/oae_mul.sv
`timescale 1ns / 1ps
`default_nettype none
module oae_mul import oae_pkg::*; (
    input  wire logic                     aclk,
    input  wire logic signed [MUL_W-1:0]  a,
    input  wire logic signed [MUL_W-1:0]  b,
    output logic signed [MUL_PW-1:0]      p
);

    logic signed [MUL_PW-1:0] p_reg;

    always_ff @(posedge aclk) begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule
`default_nettype wire

>>> hw/rtl/oae_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none
module oae_sqrt import oae_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [63:0] radicand,
    output logic             done,
    output logic [31:0]      root
);

    logic [63:0] rad_reg;
    logic [33:0] rem_reg;
    logic [31:0] root_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [33:0] rem_sh;
    logic [33:0] trial;

    always_comb begin
        rem_sh = {rem_reg[31:0], rad_reg[63:62]};
        trial  = {root_reg, 2'b01};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            rad_reg <= {rad_reg[61:0], 2'b00};
            if (rem_sh >= trial) begin
                rem_reg  <= rem_sh - trial;
                root_reg <= {root_reg[30:0], 1'b1};
            end else begin
                rem_reg  <= rem_sh;
                root_reg <= {root_reg[30:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule
`default_nettype wire

>>> hw/rtl/oae_div.sv
`timescale 1ns / 1ps
`default_nettype none
module oae_div import oae_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [31:0] dividend_hi,
    input  wire logic [31:0] divisor,
    output logic             done,
    output logic [31:0]      quotient
);

    // The dividend is dividend_hi followed by 32 zero bits; dividend_hi is
    // below the divisor, so the quotient fits in 32 bits.
    logic [32:0] rem_reg;
    logic [31:0] q_reg;
    logic [31:0] dsr_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [32:0] rem_sh;

    always_comb begin
        rem_sh = {rem_reg[31:0], 1'b0};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= {1'b0, dividend_hi};
            dsr_reg <= divisor;
            q_reg   <= '0;
        end else if (busy_reg) begin
            if (rem_sh >= {1'b0, dsr_reg}) begin
                rem_reg <= rem_sh - {1'b0, dsr_reg};
                q_reg   <= {q_reg[30:0], 1'b1};
            end else begin
                rem_reg <= rem_sh;
                q_reg   <= {q_reg[30:0], 1'b0};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule
`default_nettype wire

>>> hw/rtl/oae_cordic.sv
`timescale 1ns / 1ps
`default_nettype none
module oae_cordic import oae_pkg::*; #(
    parameter int STEPS = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire cordic_req_t          req,
    input  wire logic signed [CW-1:0] x_in,
    input  wire logic signed [CW-1:0] y_in,
    input  wire logic signed [CW-1:0] z_in,
    output logic                      done,
    output logic signed [CW-1:0]      x_out,
    output logic signed [CW-1:0]      y_out,
    output logic signed [CW-1:0]      z_out
);

    logic signed [CW-1:0] x_reg;
    logic signed [CW-1:0] y_reg;
    logic signed [CW-1:0] z_reg;
    logic                 vec_reg;
    logic [4:0]           i_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    logic signed [CW-1:0] at;
    logic                 sigma;

    always_comb begin
        xs    = x_reg >>> i_reg;
        ys    = y_reg >>> i_reg;
        at    = $signed({{(CW-30){1'b0}}, ATAN_TAB[i_reg]});
        sigma = vec_reg ? y_reg[CW-1] : !z_reg[CW-1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            i_reg    <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                i_reg    <= '0;
            end else if (busy_reg) begin
                i_reg <= i_reg + 5'd1;
                if (i_reg == 5'(STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            vec_reg <= req.vec;
            if (req.vec && x_in[CW-1]) begin
                x_reg <= -x_in;
                y_reg <= -y_in;
                z_reg <= y_in[CW-1] ? -PI_Q30 : PI_Q30;
            end else begin
                x_reg <= x_in;
                y_reg <= y_in;
                z_reg <= req.vec ? '0 : z_in;
            end
        end else if (busy_reg) begin
            if (sigma) begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - at;
            end else begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + at;
            end
        end
    end

    assign done  = done_reg;
    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule
`default_nettype wire
